/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on a clock, off while reset is high
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion sampled on a clock, checked during reset as well
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/drns_pkg.sv */
// types, constants and codes of the directional nearest rectangle search
package drns_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int SLOT_W  = 4;
   localparam int CSR_W   = 5;
   localparam int COORD_W = 10;
   localparam int EDGE_W  = COORD_W + 1;
   localparam int D2_W    = 2 * EDGE_W + 1;

   localparam int DRAIN_CYCLES = 2;
   localparam int DRAIN_W      = (DRAIN_CYCLES > 1) ? $clog2(DRAIN_CYCLES) : 1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic               label;
   } entry_type;

   typedef struct packed {
      logic [EDGE_W-1:0] x_lo;
      logic [EDGE_W-1:0] y_lo;
      logic [EDGE_W-1:0] x_hi;
      logic [EDGE_W-1:0] y_hi;
      logic [EDGE_W-1:0] cx;
      logic [EDGE_W-1:0] cy;
   } act_ref_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [D2_W-1:0]  d2;
   } cand_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACT,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

/* src/drns_eval.sv */
// candidate filter and squared centre distance, two register stages
module drns_eval (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [drns_pkg::IDX_W-1:0]        in_idx,
   input  drns_pkg::entry_type               entry,
   input  drns_pkg::act_ref_type             act_ref,
   input  logic [1:0]                        dir,
   input  logic [drns_pkg::IDX_W-1:0]        act_idx,
   output drns_pkg::cand_type                cand
);

   localparam int EW = drns_pkg::EDGE_W;

   logic [EW-1:0] c_x_lo;
   logic [EW-1:0] c_y_lo;
   logic [EW-1:0] c_x_hi;
   logic [EW-1:0] c_y_hi;
   logic [EW-1:0] c_cx;
   logic [EW-1:0] c_cy;
   logic          beyond;
   logic          keep;
   logic [EW-1:0] ux_in;
   logic [EW-1:0] uy_in;

   logic                       s1_valid_ff;
   logic [drns_pkg::IDX_W-1:0] s1_idx_ff;
   logic [EW-1:0]              ux_ff;
   logic [EW-1:0]              uy_ff;

   logic [2*EW-1:0]            sqx;
   logic [2*EW-1:0]            sqy;
   logic [drns_pkg::D2_W-1:0]  d2_in;

   logic                       s2_valid_ff;
   logic [drns_pkg::IDX_W-1:0] s2_idx_ff;
   logic [drns_pkg::D2_W-1:0]  d2_ff;

   always_comb begin
      c_x_lo = EW'(entry.x);
      c_y_lo = EW'(entry.y);
      c_x_hi = EW'(entry.x) + EW'(entry.w);
      c_y_hi = EW'(entry.y) + EW'(entry.h);
      c_cx   = EW'(entry.x) + EW'(entry.w >> 1);
      c_cy   = EW'(entry.y) + EW'(entry.h >> 1);
      case (dir)
         drns_pkg::DIR_UP:    beyond = (c_y_hi <= act_ref.y_lo);
         drns_pkg::DIR_RIGHT: beyond = (c_x_lo >= act_ref.x_hi);
         drns_pkg::DIR_DOWN:  beyond = (c_y_lo >= act_ref.y_hi);
         drns_pkg::DIR_LEFT:  beyond = (c_x_hi <= act_ref.x_lo);
         default:             beyond = 1'b0;
      endcase
      keep  = in_valid && (in_idx != act_idx) && !entry.label && beyond;
      ux_in = (act_ref.cx >= c_cx) ? (act_ref.cx - c_cx) : (c_cx - act_ref.cx);
      uy_in = (act_ref.cy >= c_cy) ? (act_ref.cy - c_cy) : (c_cy - act_ref.cy);
   end

   always_comb begin
      sqx   = ux_ff * ux_ff;
      sqy   = uy_ff * uy_ff;
      d2_in = drns_pkg::D2_W'(sqx) + drns_pkg::D2_W'(sqy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= keep;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_idx_ff <= in_idx;
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      s2_idx_ff <= s1_idx_ff;
      d2_ff     <= d2_in;
   end

   assign cand.valid = s2_valid_ff;
   assign cand.idx   = s2_idx_ff;
   assign cand.d2    = d2_ff;

endmodule

/* src/directional_nearest_rect_search.sv */
// top level: rectangle table, query sequencer and nearest candidate tracking
//
// one request channel (start / busy) carries either a table write or a query;
// a request is taken on a rising edge with start high and busy low.
// a write stores the rectangle into the table memory in that same edge, gives
// no response and leaves busy low, so a write can be issued every cycle while
// no query holds busy. a query raises busy: the active entry is read, then
// the table is scanned one entry per cycle through the memory read port, the
// distance pipeline drains and the response is shown. the scan covers n
// entries, n being the entry count saturated at 16; with no active entry the
// query goes straight to the response. the response is on rsp_found /
// rsp_found_index for one cycle with rsp_strobe high; the receiver cannot
// stall it. csr_write_enable writes the entry count; the user must write it
// only while busy is low, the block does not enforce this. reset clears the
// sequencer and the entry count; table contents are undefined until written
// and must be written before a query reads them.
module directional_nearest_rect_search (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [drns_pkg::SLOT_W-1:0]    req_entry_index,
   input  logic [drns_pkg::COORD_W-1:0]   req_rect_x,
   input  logic [drns_pkg::COORD_W-1:0]   req_rect_y,
   input  logic [drns_pkg::COORD_W-1:0]   req_rect_width,
   input  logic [drns_pkg::COORD_W-1:0]   req_rect_height,
   input  logic                           req_is_label,
   input  logic [1:0]                     req_direction,
   input  logic [drns_pkg::SLOT_W-1:0]    req_active_index,
   input  logic                           req_has_active,
   input  logic                           csr_write_enable,
   input  logic [drns_pkg::CSR_W-1:0]     csr_write_data,
   output logic                           rsp_strobe,
   output logic                           rsp_found,
   output logic [drns_pkg::SLOT_W-1:0]    rsp_found_index
);

   localparam int IW = drns_pkg::IDX_W;
   localparam int CW = drns_pkg::CNT_W;
   localparam int EW = drns_pkg::EDGE_W;

   drns_pkg::entry_type mem [drns_pkg::MAX_ENTRIES];
   drns_pkg::entry_type rd_data_ff;
   logic                rd_en;
   logic [IW-1:0]       rd_addr;

   drns_pkg::state_type state_ff;
   drns_pkg::state_type state_in;

   logic [drns_pkg::CSR_W-1:0] count_ff;
   logic [CW-1:0]              n_ff;
   logic [IW-1:0]              act_idx_ff;
   logic [1:0]                 dir_ff;
   logic [CW-1:0]              rd_idx_ff;
   logic [CW-1:0]              rd_idx_in;
   logic                       p0_valid_ff;
   logic                       p0_valid_in;
   logic [IW-1:0]              p0_idx_ff;
   logic [drns_pkg::DRAIN_W-1:0] drain_ff;
   logic [drns_pkg::DRAIN_W-1:0] drain_in;
   drns_pkg::act_ref_type      act_ref_ff;
   drns_pkg::act_ref_type      act_ref_in;

   logic                       hit_ff;
   logic                       hit_in;
   logic [IW-1:0]              best_idx_ff;
   logic [IW-1:0]              best_idx_in;
   logic [drns_pkg::D2_W-1:0]  best_d_ff;
   logic [drns_pkg::D2_W-1:0]  best_d_in;

   drns_pkg::cand_type         cand;

   logic accept;
   logic query_go;
   logic write_go;

   assign busy     = (state_ff != drns_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign query_go = accept && (req_operation == drns_pkg::OP_QUERY);
   assign write_go = accept && (req_operation == drns_pkg::OP_WRITE)
                     && (32'(req_entry_index) < drns_pkg::MAX_ENTRIES);

   // table memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (write_go) begin
         mem[IW'(req_entry_index)] <= '{x: req_rect_x, y: req_rect_y, w: req_rect_width,
                                        h: req_rect_height, label: req_is_label};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in    = state_ff;
      rd_en       = 1'b0;
      rd_addr     = rd_idx_ff[IW-1:0];
      rd_idx_in   = rd_idx_ff;
      p0_valid_in = 1'b0;
      drain_in    = drain_ff;
      act_ref_in  = act_ref_ff;
      case (state_ff)
         drns_pkg::ST_IDLE: begin
            if (query_go) begin
               if (req_has_active && (32'(req_active_index) < drns_pkg::MAX_ENTRIES)) begin
                  rd_en    = 1'b1;
                  rd_addr  = IW'(req_active_index);
                  state_in = drns_pkg::ST_ACT;
               end else begin
                  state_in = drns_pkg::ST_DONE;
               end
            end
         end
         drns_pkg::ST_ACT: begin
            act_ref_in.x_lo = EW'(rd_data_ff.x);
            act_ref_in.y_lo = EW'(rd_data_ff.y);
            act_ref_in.x_hi = EW'(rd_data_ff.x) + EW'(rd_data_ff.w);
            act_ref_in.y_hi = EW'(rd_data_ff.y) + EW'(rd_data_ff.h);
            act_ref_in.cx   = EW'(rd_data_ff.x) + EW'(rd_data_ff.w >> 1);
            act_ref_in.cy   = EW'(rd_data_ff.y) + EW'(rd_data_ff.h >> 1);
            rd_idx_in       = '0;
            state_in        = drns_pkg::ST_SCAN;
         end
         drns_pkg::ST_SCAN: begin
            if (rd_idx_ff == n_ff) begin
               drain_in = '0;
               state_in = drns_pkg::ST_DRAIN;
            end else begin
               rd_en       = 1'b1;
               p0_valid_in = 1'b1;
               rd_idx_in   = rd_idx_ff + CW'(1);
            end
         end
         drns_pkg::ST_DRAIN: begin
            if (drain_ff == drns_pkg::DRAIN_W'(drns_pkg::DRAIN_CYCLES - 1)) begin
               state_in = drns_pkg::ST_DONE;
            end else begin
               drain_in = drain_ff + drns_pkg::DRAIN_W'(1);
            end
         end
         drns_pkg::ST_DONE: begin
            state_in = drns_pkg::ST_IDLE;
         end
         default: begin
            state_in = drns_pkg::ST_IDLE;
         end
      endcase
   end

   // running minimum, strict less so the lowest slot keeps a tie
   always_comb begin
      hit_in      = hit_ff;
      best_idx_in = best_idx_ff;
      best_d_in   = best_d_ff;
      if (query_go) begin
         hit_in      = 1'b0;
         best_idx_in = '0;
      end else if (cand.valid && (!hit_ff || (cand.d2 < best_d_ff))) begin
         hit_in      = 1'b1;
         best_idx_in = cand.idx;
         best_d_in   = cand.d2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= drns_pkg::ST_IDLE;
         count_ff    <= '0;
         p0_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
         best_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         p0_valid_ff <= p0_valid_in;
         hit_ff      <= hit_in;
         best_idx_ff <= best_idx_in;
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (query_go) begin
         n_ff       <= (count_ff > drns_pkg::CSR_W'(drns_pkg::MAX_ENTRIES))
                       ? CW'(drns_pkg::MAX_ENTRIES) : CW'(count_ff);
         act_idx_ff <= IW'(req_active_index);
         dir_ff     <= req_direction;
      end
      rd_idx_ff  <= rd_idx_in;
      p0_idx_ff  <= rd_idx_ff[IW-1:0];
      drain_ff   <= drain_in;
      act_ref_ff <= act_ref_in;
      best_d_ff  <= best_d_in;
   end

   drns_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .in_valid (p0_valid_ff),
      .in_idx   (p0_idx_ff),
      .entry    (rd_data_ff),
      .act_ref  (act_ref_ff),
      .dir      (dir_ff),
      .act_idx  (act_idx_ff),
      .cand     (cand)
   );

   assign rsp_strobe      = (state_ff == drns_pkg::ST_DONE);
   assign rsp_found       = hit_ff;
   assign rsp_found_index = drns_pkg::SLOT_W'(best_idx_ff);

endmodule

/* src/drns_checker.sv */
// port level checks of the search block and their binding to the top level
`include "assert_macros.svh"

module drns_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_operation,
   input logic                        rsp_strobe,
   input logic                        rsp_found,
   input logic [drns_pkg::SLOT_W-1:0] rsp_found_index
);

   `ASSERT_CLKD(a_strobe_while_busy, clock, reset, rsp_strobe |-> busy, "response outside a query")
   `ASSERT_CLKD(a_idle_after_rsp, clock, reset, rsp_strobe |=> !busy, "busy held past response")
   `ASSERT_CLKD(a_miss_index_zero, clock, reset, (rsp_strobe && !rsp_found) |-> (rsp_found_index == '0), "nonzero index on miss")
   `ASSERT_CLKD(a_query_busy, clock, reset, (start && !busy && (req_operation == drns_pkg::OP_QUERY)) |=> busy, "query request not taken")
   `ASSERT_CLKD(a_write_no_busy, clock, reset, (start && !busy && (req_operation == drns_pkg::OP_WRITE)) |=> (!busy && !rsp_strobe), "write request raised busy")

endmodule

bind directional_nearest_rect_search drns_checker u_drns_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .rsp_strobe      (rsp_strobe),
   .rsp_found       (rsp_found),
   .rsp_found_index (rsp_found_index)
);
